/* rtl/cirf_pkg.sv */
// Shared types and codes for the CAN identifier allowlist and rate filter.
package cirf_pkg;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_ENFORCE_LENGTH = 2'd0;
  localparam logic [1:0] REG_ENFORCE_RATE   = 2'd1;
  localparam logic [1:0] REG_RULE_COUNT     = 2'd2;

  typedef enum logic [2:0] {
    V_PASS    = 3'd0,
    V_UNKNOWN = 3'd1,
    V_LENGTH  = 3'd2,
    V_RATE    = 3'd3,
    V_WRITTEN = 3'd4
  } verdict_t;

  typedef struct packed {
    logic [31:0] id;
    logic [3:0]  len;
    logic [31:0] period;
  } rule_t;

  typedef struct packed {
    logic [63:0] last;
    logic [31:0] passes;
    logic [31:0] drops;
  } dyn_t;

  typedef struct packed {
    logic capture;
    logic scan;
    logic dyn_read;
    logic eval;
    logic commit;
    logic rule_write;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic op_in;
    logic match;
    logic scan_end;
    logic clear_end;
    logic out_free;
  } status_t;

endpackage

/* rtl/cirf_dp.sv */
// Datapath of the CAN filter: rule and counter memories, scan, verdict and result register.
module cirf_dp #(
  parameter int MAX_RULES = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cirf_pkg::cmd_t          cmd,
  output cirf_pkg::status_t       st,
  input  logic                    enforce_length,
  input  logic                    enforce_rate,
  input  logic [6:0]              rule_count,
  input  logic                    operation,
  input  logic [5:0]              rule_index,
  input  logic [31:0]             can_id,
  input  logic [3:0]              frame_length,
  input  logic [3:0]              rule_length,
  input  logic [31:0]             rule_period,
  input  logic [63:0]             timestamp,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2:0]              verdict,
  output logic                    matched,
  output logic [5:0]              matched_index,
  output logic [31:0]             rule_passes,
  output logic [31:0]             rule_drops,
  output logic [63:0]             verdict_total
);

  localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W = $clog2(MAX_RULES + 1);

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  cirf_pkg::rule_t rule_mem [MAX_RULES];
  cirf_pkg::dyn_t  dyn_mem  [MAX_RULES];
  cirf_pkg::rule_t rule_rd;
  cirf_pkg::dyn_t  dyn_rd;

  logic [5:0]  idx_q;
  logic [31:0] id_q;
  logic [3:0]  flen_q;
  logic [3:0]  rlen_q;
  logic [31:0] period_q;
  logic [63:0] ts_q;

  logic [CNT_W-1:0] active;
  logic [CNT_W-1:0] scan_addr;
  logic [IDX_W-1:0] cmp_addr;
  logic             cmp_valid;
  logic             scan_more;
  logic             match;
  logic             hit;
  logic [IDX_W-1:0] hit_slot;
  logic [3:0]       hit_len;
  logic [31:0]      hit_period;

  logic [IDX_W-1:0] clear_addr;
  logic             in_table;
  logic [IDX_W-1:0] waddr;

  logic              dyn_we;
  logic [IDX_W-1:0]  dyn_waddr;
  cirf_pkg::dyn_t    dyn_wdata;

  logic [63:0]        gap;
  logic               len_bad;
  logic               too_fast;
  cirf_pkg::verdict_t v_now;
  cirf_pkg::verdict_t verdict_q;
  cirf_pkg::dyn_t     new_dyn;

  logic [63:0] totals [4];
  logic [63:0] tot_inc;

  // Clamp the active rule count to the table depth.
  assign active = ({25'd0, rule_count} >= 32'(MAX_RULES)) ? CNT_W'(MAX_RULES)
                                                          : CNT_W'(rule_count);
  assign scan_more = scan_addr < active;
  assign match     = cmp_valid && (rule_rd.id == id_q);
  assign in_table  = {26'd0, idx_q} < 32'(MAX_RULES);
  assign waddr     = IDX_W'(idx_q);

  assign st.op_in     = operation;
  assign st.match     = match;
  assign st.scan_end  = !cmp_valid && !scan_more;
  assign st.clear_end = clear_addr == IDX_W'(MAX_RULES - 1);
  assign st.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_q    <= rule_index;
      id_q     <= can_id;
      flen_q   <= frame_length;
      rlen_q   <= rule_length;
      period_q <= rule_period;
      ts_q     <= timestamp;
    end
  end

  // Scan: issue one read per cycle, compare the previous read.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
      hit       <= 1'b0;
      scan_addr <= '0;
    end else begin
      cmp_valid <= cmd.scan && scan_more;
      if (cmd.capture) begin
        hit       <= 1'b0;
        scan_addr <= '0;
      end else if (cmd.scan && scan_more) begin
        scan_addr <= scan_addr + CNT_W'(1);
      end
      if (cmd.scan && match) begin
        hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && scan_more) begin
      cmp_addr <= scan_addr[IDX_W-1:0];
    end
    if (cmd.scan && match) begin
      hit_slot   <= cmp_addr;
      hit_len    <= rule_rd.len;
      hit_period <= rule_rd.period;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rule_write && in_table) begin
      rule_mem[waddr] <= '{id: id_q, len: rlen_q, period: period_q};
    end
    if (cmd.scan && scan_more) begin
      rule_rd <= rule_mem[scan_addr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear) begin
      clear_addr <= clear_addr + IDX_W'(1);
    end
  end

  always_comb begin
    dyn_we    = 1'b0;
    dyn_waddr = clear_addr;
    dyn_wdata = '0;
    if (cmd.clear) begin
      dyn_we = 1'b1;
    end else if (cmd.rule_write && in_table) begin
      dyn_we    = 1'b1;
      dyn_waddr = waddr;
    end else if (cmd.commit && hit) begin
      dyn_we    = 1'b1;
      dyn_waddr = hit_slot;
      dyn_wdata = new_dyn;
    end
  end

  always_ff @(posedge clk) begin
    if (dyn_we) begin
      dyn_mem[dyn_waddr] <= dyn_wdata;
    end
    if (cmd.dyn_read) begin
      dyn_rd <= dyn_mem[hit_slot];
    end
  end

  // Verdict: unknown, then length, then rate.
  always_comb begin
    gap      = ts_q - dyn_rd.last;
    len_bad  = enforce_length && (flen_q != hit_len);
    too_fast = enforce_rate && (dyn_rd.last != 64'd0) && (gap < {32'd0, hit_period});
    priority if (!hit) v_now = cirf_pkg::V_UNKNOWN;
    else if (len_bad)  v_now = cirf_pkg::V_LENGTH;
    else if (too_fast) v_now = cirf_pkg::V_RATE;
    else               v_now = cirf_pkg::V_PASS;
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      verdict_q <= v_now;
      if (v_now == cirf_pkg::V_PASS) begin
        new_dyn <= '{last: ts_q, passes: sat_inc(dyn_rd.passes), drops: dyn_rd.drops};
      end else begin
        new_dyn <= '{last: dyn_rd.last, passes: dyn_rd.passes, drops: sat_inc(dyn_rd.drops)};
      end
    end
  end

  assign tot_inc = totals[verdict_q[1:0]] + 64'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        totals[i] <= '0;
      end
    end else begin
      if (cmd.commit) begin
        totals[verdict_q[1:0]] <= tot_inc;
        out_valid <= 1'b1;
      end else if (cmd.rule_write) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      verdict       <= verdict_q;
      matched       <= hit;
      matched_index <= hit ? 6'(hit_slot) : 6'd0;
      rule_passes   <= hit ? new_dyn.passes : 32'd0;
      rule_drops    <= hit ? new_dyn.drops : 32'd0;
      verdict_total <= tot_inc;
    end else if (cmd.rule_write) begin
      verdict       <= cirf_pkg::V_WRITTEN;
      matched       <= 1'b0;
      matched_index <= idx_q;
      rule_passes   <= 32'd0;
      rule_drops    <= 32'd0;
      verdict_total <= 64'd0;
    end
  end

  a_hit_reported: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && hit |=> out_valid && matched)
    else $error("matched frame not reported as matched");

  a_unknown_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == cirf_pkg::V_UNKNOWN |->
      !matched && matched_index == 6'd0 && rule_passes == 32'd0 && rule_drops == 32'd0)
    else $error("unknown id result carries rule data");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> 32'(cmp_addr) < 32'(active))
    else $error("scan compared a slot beyond the active count");

endmodule

/* rtl/cirf_ctrl.sv */
// Controller state machine of the CAN filter: clearing pass, scan, counter read, evaluate, commit, rule write.
module cirf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cirf_pkg::status_t st,
  output cirf_pkg::cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_SCAN   = 7'b0000100,
    S_DYN    = 7'b0001000,
    S_EVAL   = 7'b0010000,
    S_COMMIT = 7'b0100000,
    S_WRITE  = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign in_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clear_end) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = st.op_in ? S_WRITE : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        priority if (st.match) state_next = S_DYN;
        else if (st.scan_end)  state_next = S_EVAL;
      end
      S_DYN: begin
        cmd.dyn_read = 1'b1;
        state_next   = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (st.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_WRITE: begin
        if (st.out_free) begin
          cmd.rule_write = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_commit_waits: assert property (@(posedge clk) disable iff (rst)
    state == S_COMMIT && !st.out_free |=> state == S_COMMIT)
    else $error("commit left while result register was full");

endmodule

/* rtl/can_id_allowlist_rate_filter.sv */
// Top level of the CAN identifier allowlist filter with per-rule rate limiting.
// Frame item: accepted in idle, then the rule slots are scanned in order up to
//   min(rule_count, MAX_RULES), stopping at the first matching slot; a match reads the
//   rule's counters, then the verdict is evaluated and the result registered at commit.
// Rule write item: accepted in idle, result registered at the write. One item in
//   flight at a time, the linear scan over the rule memory taking one slot per cycle;
//   a result waiting on out_ready holds the commit or the rule write.
// Reset: synchronous; afterwards a clearing pass over all MAX_RULES slots zeroes the
//   counter memory with in_ready low. APB writes are taken at all times.
module can_id_allowlist_rate_filter #(
  parameter int MAX_RULES = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  // APB configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cirf_pkg::ADDR_W-1:0]  paddr,
  input  logic [cirf_pkg::DATA_W-1:0]  pwdata,
  output logic [cirf_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  // input item channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         operation,
  input  logic [5:0]                   rule_index,
  input  logic [31:0]                  can_id,
  input  logic [3:0]                   frame_length,
  input  logic [3:0]                   rule_length,
  input  logic [31:0]                  rule_period,
  input  logic [63:0]                  timestamp,
  // result item channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   verdict,
  output logic                         matched,
  output logic [5:0]                   matched_index,
  output logic [31:0]                  rule_passes,
  output logic [31:0]                  rule_drops,
  output logic [63:0]                  verdict_total
);

  logic              enforce_length;
  logic              enforce_rate;
  logic [6:0]        rule_count;
  logic              cfg_write;
  cirf_pkg::cmd_t    cmd;
  cirf_pkg::status_t st;

  // Registers sit at word addresses; the word index selects the register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      enforce_length <= 1'b1;
      enforce_rate   <= 1'b1;
      rule_count     <= 7'd0;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        cirf_pkg::REG_ENFORCE_LENGTH: enforce_length <= pwdata[0];
        cirf_pkg::REG_ENFORCE_RATE:   enforce_rate   <= pwdata[0];
        cirf_pkg::REG_RULE_COUNT:     rule_count     <= pwdata[6:0];
        default: ;  // drop writes to unmapped words
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      cirf_pkg::REG_ENFORCE_LENGTH: prdata = {31'd0, enforce_length};
      cirf_pkg::REG_ENFORCE_RATE:   prdata = {31'd0, enforce_rate};
      cirf_pkg::REG_RULE_COUNT:     prdata = {25'd0, rule_count};
      default:                      prdata = '0;
    endcase
  end

  // Sequencer: clearing pass, then per item scan / counter read / verdict / commit, or a rule write.
  cirf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Rule table, per-rule counters, verdict totals and the result register.
  cirf_dp #(
    .MAX_RULES (MAX_RULES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .enforce_length (enforce_length),
    .enforce_rate   (enforce_rate),
    .rule_count     (rule_count),
    .operation      (operation),
    .rule_index     (rule_index),
    .can_id         (can_id),
    .frame_length   (frame_length),
    .rule_length    (rule_length),
    .rule_period    (rule_period),
    .timestamp      (timestamp),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .verdict        (verdict),
    .matched        (matched),
    .matched_index  (matched_index),
    .rule_passes    (rule_passes),
    .rule_drops     (rule_drops),
    .verdict_total  (verdict_total)
  );

endmodule
